@@ sv/tefb_pkg.sv @@
// Shared types, constants and helpers for the tile edge feather blend unit.
// Depends on nothing; used by tefb_div_pipe and tile_edge_feather_blend_unit.
package tefb_pkg;

    localparam int MAX_TILE   = 4096;
    localparam int CFG_W      = 13;
    localparam int POS_W      = 12;
    localparam int VAL_W      = 32;
    localparam int FRAC_W     = 15;
    localparam int WGT_W      = 17;
    localparam int PROD_W     = VAL_W + WGT_W + 1;
    localparam int SUM_W      = PROD_W + 2;
    localparam int DIV_STEPS  = FRAC_W;
    localparam int ADDR_W     = 5;
    localparam int IN_DATA_W  = 160;
    localparam int OUT_DATA_W = 40;

    localparam logic [WGT_W-1:0]  ONE_Q16  = 17'd65536;
    localparam logic [WGT_W-1:0]  HALF_Q16 = 17'd32768;
    localparam logic [WGT_W-1:0]  RECIP3   = 17'd43691;
    localparam logic [CFG_W-1:0]  MAX_SIZE = CFG_W'(MAX_TILE);

    localparam logic [2:0] REG_TILE_SIZE = 3'd0;
    localparam logic [2:0] REG_LEFT      = 3'd1;
    localparam logic [2:0] REG_RIGHT     = 3'd2;
    localparam logic [2:0] REG_BOTTOM    = 3'd3;
    localparam logic [2:0] REG_TOP       = 3'd4;
    localparam logic [2:0] REG_PRESENT   = 3'd5;
    localparam logic [2:0] REG_ENABLE    = 3'd6;

    localparam logic [7:0] MASK_LL = 8'h19;
    localparam logic [7:0] MASK_LR = 8'h2A;
    localparam logic [7:0] MASK_UL = 8'h45;
    localparam logic [7:0] MASK_UR = 8'h86;

    typedef enum logic [3:0] {
        RGN_NONE   = 4'd0,
        RGN_LEFT   = 4'd1,
        RGN_RIGHT  = 4'd2,
        RGN_TOP    = 4'd3,
        RGN_BOTTOM = 4'd4,
        RGN_LL     = 4'd5,
        RGN_LR     = 4'd6,
        RGN_UL     = 4'd7,
        RGN_UR     = 4'd8
    } t_region;

    typedef struct packed {
        t_region                   region;
        logic                      cblank;
        logic signed [VAL_W-1:0]   c;
        logic signed [VAL_W-1:0]   s;
        logic signed [VAL_W-1:0]   t;
        logic signed [VAL_W-1:0]   g;
        logic        [CFG_W-1:0]   hn;
        logic        [CFG_W-1:0]   hd;
        logic        [CFG_W-1:0]   vn;
        logic        [CFG_W-1:0]   vd;
    } t_item;

    typedef struct packed {
        logic valid;
        logic advance;
    } t_pipe_ctl;

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [CFG_W:0] div_step(input logic [CFG_W-1:0] rem,
                                                input logic [CFG_W-1:0] den);
        logic [CFG_W:0] dbl;
        logic [CFG_W:0] diff;
        dbl  = {rem, 1'b0};
        diff = dbl - {1'b0, den};
        if (dbl >= {1'b0, den}) begin
            div_step = {1'b1, diff[CFG_W-1:0]};
        end else begin
            div_step = {1'b0, dbl[CFG_W-1:0]};
        end
    endfunction

    // floor(x / 3) for x below 2^17
    function automatic logic [WGT_W-1:0] div3(input logic [WGT_W-1:0] x);
        logic [2*WGT_W-1:0] p;
        p = x * RECIP3;
        div3 = p[2*WGT_W-1:WGT_W];
    endfunction

endpackage

@@ sv/tefb_div_pipe.sv @@
// Pipelined restoring divider: fh = hn*32768/hd and fv = vn*32768/vd, one bit a stage.
// Depends on tefb_pkg; the pixel word rides along with the partial quotients.
module tefb_div_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tefb_pkg::t_pipe_ctl            i_ctl,
    input  tefb_pkg::t_item                i_item,
    output logic                           o_valid,
    output tefb_pkg::t_item                o_item,
    output logic [tefb_pkg::FRAC_W-1:0]    o_fh,
    output logic [tefb_pkg::FRAC_W-1:0]    o_fv
);
    import tefb_pkg::*;

    logic              r_valid [DIV_STEPS];
    t_item             r_item  [DIV_STEPS];
    logic [CFG_W-1:0]  r_rh    [DIV_STEPS];
    logic [CFG_W-1:0]  r_rv    [DIV_STEPS];
    logic [FRAC_W-1:0] r_qh    [DIV_STEPS];
    logic [FRAC_W-1:0] r_qv    [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic              p_valid;
            t_item             p_item;
            logic [CFG_W-1:0]  p_rh;
            logic [CFG_W-1:0]  p_rv;
            logic [FRAC_W-1:0] p_qh;
            logic [FRAC_W-1:0] p_qv;
            logic [CFG_W:0]    n_sh;
            logic [CFG_W:0]    n_sv;

            if (k == 0) begin : g_first
                always_comb begin
                    p_valid = i_ctl.valid;
                    p_item  = i_item;
                    p_rh    = i_item.hn;
                    p_rv    = i_item.vn;
                    p_qh    = '0;
                    p_qv    = '0;
                end
            end else begin : g_next
                always_comb begin
                    p_valid = r_valid[k-1];
                    p_item  = r_item[k-1];
                    p_rh    = r_rh[k-1];
                    p_rv    = r_rv[k-1];
                    p_qh    = r_qh[k-1];
                    p_qv    = r_qv[k-1];
                end
            end

            always_comb begin
                n_sh = div_step(p_rh, p_item.hd);
                n_sv = div_step(p_rv, p_item.vd);
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_ctl.advance) begin
                    r_valid[k] <= p_valid;
                end
                if (i_ctl.advance) begin
                    r_item[k] <= p_item;
                    r_rh[k]   <= n_sh[CFG_W-1:0];
                    r_rv[k]   <= n_sv[CFG_W-1:0];
                    r_qh[k]   <= {p_qh[FRAC_W-2:0], n_sh[CFG_W]};
                    r_qv[k]   <= {p_qv[FRAC_W-2:0], n_sv[CFG_W]};
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_item  = r_item[DIV_STEPS-1];
    assign o_fh    = r_qh[DIV_STEPS-1];
    assign o_fv    = r_qv[DIV_STEPS-1];

endmodule

@@ sv/tile_edge_feather_blend_unit.sv @@
// Tile edge feather blend unit: top level with register port, region decode and blend.
// Depends on tefb_pkg and tefb_div_pipe.
//
// Each input word is one pixel; each output word is its blended or unchanged value.
// The pipeline takes one word per clock while the output word is not held. It has one
// decode stage, fifteen divider stages (one quotient bit each), two weight stages,
// one multiply stage, one sum stage and the output register, and stalls as a whole
// while the output word is held. The user must write registers only when idle (unenforced).
module tile_edge_feather_blend_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tefb_pkg::ADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // col[11:0] row[23:12] center_value[55:24] center_blank[56] side_value[88:57]
    // side_blank[89] vert_value[121:90] vert_blank[122] diag_value[154:123]
    // diag_blank[155], zero above
    input  logic [tefb_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_value[31:0] out_blank[32] region[36:33], zero above
    output logic [tefb_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import tefb_pkg::*;

    logic [CFG_W-1:0] r_tile_size;
    logic [CFG_W-1:0] r_left;
    logic [CFG_W-1:0] r_right;
    logic [CFG_W-1:0] r_bottom;
    logic [CFG_W-1:0] r_top;
    logic [7:0]       r_present;
    logic             r_enable;

    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_size <= CFG_W'(512);
            r_left      <= '0;
            r_right     <= '0;
            r_bottom    <= '0;
            r_top       <= '0;
            r_present   <= '0;
            r_enable    <= 1'b1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TILE_SIZE: r_tile_size <= pwdata[CFG_W-1:0];
                REG_LEFT:      r_left      <= pwdata[CFG_W-1:0];
                REG_RIGHT:     r_right     <= pwdata[CFG_W-1:0];
                REG_BOTTOM:    r_bottom    <= pwdata[CFG_W-1:0];
                REG_TOP:       r_top       <= pwdata[CFG_W-1:0];
                REG_PRESENT:   r_present   <= pwdata[7:0];
                REG_ENABLE:    r_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TILE_SIZE: prdata = {19'd0, r_tile_size};
            REG_LEFT:      prdata = {19'd0, r_left};
            REG_RIGHT:     prdata = {19'd0, r_right};
            REG_BOTTOM:    prdata = {19'd0, r_bottom};
            REG_TOP:       prdata = {19'd0, r_top};
            REG_PRESENT:   prdata = {24'd0, r_present};
            REG_ENABLE:    prdata = {31'd0, r_enable};
            default:       prdata = '0;
        endcase
    end

    // global advance: the pipeline moves unless the output word is held
    logic r_out_valid;
    logic advance;

    assign advance  = !r_out_valid || m_tready;
    assign s_tready = advance;

    // decode
    logic [POS_W-1:0]        in_col;
    logic [POS_W-1:0]        in_row;
    logic                    in_cblank;
    logic signed [VAL_W-1:0] in_c;
    logic [CFG_W-1:0]        size;
    logic [CFG_W-1:0]        col13;
    logic [CFG_W-1:0]        row13;
    logic                    in_tile;
    logic                    inl, inr, inb, intp;
    logic                    ll, lr, ul, ur;
    t_item                   n_dec;

    assign in_col    = s_tdata[11:0];
    assign in_row    = s_tdata[23:12];
    assign in_cblank = s_tdata[56];
    assign in_c      = in_cblank ? '0 : $signed(s_tdata[55:24]);
    assign size      = (r_tile_size > MAX_SIZE) ? MAX_SIZE : r_tile_size;
    assign col13     = {1'b0, in_col};
    assign row13     = {1'b0, in_row};

    always_comb begin
        in_tile = r_enable && (col13 < size) && (row13 < size);
        inl    = col13 < r_left;
        inr    = ({1'b0, col13} + {1'b0, r_right}) > {1'b0, size};
        inb    = row13 < r_bottom;
        intp   = ({1'b0, row13} + {1'b0, r_top}) > {1'b0, size};
        ll     = inl && inb;
        lr     = inr && inb;
        ul     = inl && intp;
        ur     = inr && intp;

        n_dec.cblank = in_cblank;
        n_dec.c      = in_c;
        n_dec.s      = s_tdata[89]  ? in_c : $signed(s_tdata[88:57]);
        n_dec.t      = s_tdata[122] ? in_c : $signed(s_tdata[121:90]);
        n_dec.g      = s_tdata[155] ? in_c : $signed(s_tdata[154:123]);

        if (inr) begin
            n_dec.hn = size - col13;
            n_dec.hd = r_right;
        end else begin
            n_dec.hn = col13;
            n_dec.hd = r_left;
        end
        if (intp) begin
            n_dec.vn = size - row13;
            n_dec.vd = r_top;
        end else begin
            n_dec.vn = row13;
            n_dec.vd = r_bottom;
        end

        n_dec.region = RGN_NONE;
        if (in_tile) begin
            if (inl && !ll && !ul && r_present[0]) begin
                n_dec.region = RGN_LEFT;
            end else if (inr && !lr && !ur && r_present[1]) begin
                n_dec.region = RGN_RIGHT;
            end else if (intp && !ul && !ur && r_present[2]) begin
                n_dec.region = RGN_TOP;
            end else if (inb && !ll && !lr && r_present[3]) begin
                n_dec.region = RGN_BOTTOM;
            end else if (ll && (r_present & MASK_LL) == MASK_LL) begin
                n_dec.region = RGN_LL;
            end else if (lr && (r_present & MASK_LR) == MASK_LR) begin
                n_dec.region = RGN_LR;
            end else if (ul && (r_present & MASK_UL) == MASK_UL) begin
                n_dec.region = RGN_UL;
            end else if (ur && (r_present & MASK_UR) == MASK_UR) begin
                n_dec.region = RGN_UR;
            end
        end
    end

    logic  r_dec_valid;
    t_item r_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (advance) begin
            r_dec_valid <= s_tvalid;
        end
        if (advance) begin
            r_dec <= n_dec;
        end
    end

    // divide
    t_pipe_ctl         div_ctl;
    logic              div_valid;
    t_item             div_item;
    logic [FRAC_W-1:0] div_fh;
    logic [FRAC_W-1:0] div_fv;

    assign div_ctl.valid   = r_dec_valid;
    assign div_ctl.advance = advance;

    tefb_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_item  (r_dec),
        .o_valid (div_valid),
        .o_item  (div_item),
        .o_fh    (div_fh),
        .o_fv    (div_fv)
    );

    // weights: pulled h, v and the corner thirds
    logic [WGT_W-1:0] h_w;
    logic [WGT_W-1:0] v_w;
    logic [WGT_W:0]   hv_sum;
    logic [WGT_W-1:0] avg_w;

    assign h_w    = HALF_Q16 + {2'b0, div_fh};
    assign v_w    = HALF_Q16 + {2'b0, div_fv};
    assign hv_sum = {1'b0, h_w} + {1'b0, v_w};
    assign avg_w  = hv_sum[WGT_W:1];

    logic             r_w1_valid;
    t_item            r_w1_item;
    logic [WGT_W-1:0] r_h, r_v, r_wl, r_wv, r_wd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w1_valid <= 1'b0;
        end else if (advance) begin
            r_w1_valid <= div_valid;
        end
        if (advance) begin
            r_w1_item <= div_item;
            r_h       <= h_w;
            r_v       <= v_w;
            r_wl      <= div3(ONE_Q16 - h_w);
            r_wv      <= div3(ONE_Q16 - v_w);
            r_wd      <= div3(ONE_Q16 - avg_w);
        end
    end

    // select the four weights for centre, side, vertical, diagonal
    logic [WGT_W-1:0] n_wc, n_ws, n_wt, n_wg;

    always_comb begin
        case (r_w1_item.region)
            RGN_LEFT, RGN_RIGHT: begin
                n_wc = r_h;
                n_ws = ONE_Q16 - r_h;
                n_wt = '0;
                n_wg = '0;
            end
            RGN_TOP, RGN_BOTTOM: begin
                n_wc = r_v;
                n_ws = '0;
                n_wt = ONE_Q16 - r_v;
                n_wg = '0;
            end
            RGN_LL, RGN_LR, RGN_UL, RGN_UR: begin
                n_wc = ONE_Q16 - r_wl - r_wv - r_wd;
                n_ws = r_wl;
                n_wt = r_wv;
                n_wg = r_wd;
            end
            default: begin
                n_wc = ONE_Q16;
                n_ws = '0;
                n_wt = '0;
                n_wg = '0;
            end
        endcase
    end

    logic             r_w2_valid;
    t_item            r_w2_item;
    logic [WGT_W-1:0] r_wc, r_ws, r_wt, r_wg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w2_valid <= 1'b0;
        end else if (advance) begin
            r_w2_valid <= r_w1_valid;
        end
        if (advance) begin
            r_w2_item <= r_w1_item;
            r_wc      <= n_wc;
            r_ws      <= n_ws;
            r_wt      <= n_wt;
            r_wg      <= n_wg;
        end
    end

    // multiply
    logic                     r_mul_valid;
    t_item                    r_mul_item;
    logic signed [PROD_W-1:0] r_pc, r_ps, r_pt, r_pg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (advance) begin
            r_mul_valid <= r_w2_valid;
        end
        if (advance) begin
            r_mul_item <= r_w2_item;
            r_pc <= PROD_W'(r_w2_item.c * $signed({1'b0, r_wc}));
            r_ps <= PROD_W'(r_w2_item.s * $signed({1'b0, r_ws}));
            r_pt <= PROD_W'(r_w2_item.t * $signed({1'b0, r_wt}));
            r_pg <= PROD_W'(r_w2_item.g * $signed({1'b0, r_wg}));
        end
    end

    // sum
    logic                    r_sum_valid;
    t_region                 r_sum_region;
    logic                    r_sum_cblank;
    logic signed [VAL_W-1:0] r_sum_c;
    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (advance) begin
            r_sum_valid <= r_mul_valid;
        end
        if (advance) begin
            r_sum_region <= r_mul_item.region;
            r_sum_cblank <= r_mul_item.cblank;
            r_sum_c      <= r_mul_item.c;
            r_sum        <= SUM_W'(r_pc) + SUM_W'(r_ps) + SUM_W'(r_pt) + SUM_W'(r_pg);
        end
    end

    // round and output register
    logic [SUM_W-1:0]  rounded;
    logic [VAL_W-1:0]  n_value;
    logic              n_blank;

    assign rounded = r_sum + SUM_W'(HALF_Q16);

    always_comb begin
        if (r_sum_region == RGN_NONE) begin
            n_value = r_sum_c;
            n_blank = r_sum_cblank;
        end else begin
            n_value = rounded[VAL_W+15:16];
            n_blank = 1'b0;
        end
    end

    logic [VAL_W-1:0] r_out_value;
    logic             r_out_blank;
    t_region          r_out_region;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_sum_valid;
        end
        if (advance) begin
            r_out_value  <= n_value;
            r_out_blank  <= n_blank;
            r_out_region <= r_sum_region;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {3'd0, r_out_region, r_out_blank, r_out_value};

    a_blank_passthru: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && r_out_blank) |-> (r_out_region == RGN_NONE && r_out_value == '0))
        else $error("blank word with blended region or nonzero value");

    a_region_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (r_out_region <= RGN_UR))
        else $error("region code out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("output word valid right after reset");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_tready) |-> !s_tready)
        else $error("input taken while pipeline stalled");

endmodule
